// ----- rtl/atp_pkg.sv -----
// ----------------------------------------------------------------------------
// atp_pkg: shared types and constants for the accelerometer tilt block
// Holds the axis bundle, fixed-point widths and the CORDIC angle table.
// ----------------------------------------------------------------------------
package atp_pkg;

  // Width of a CORDIC operand in Q8 (covers the gain growth of the rotations).
  localparam int OpW = 28;
  // Width of the angle accumulator, centidegrees with 16 fraction bits.
  localparam int AccW = 34;
  // Number of entries in the angle table.
  localparam int TableLen = 24;
  // Width of the square-root result and of its radicand.
  localparam int RootW = 24;
  localparam int RadW = 48;

  localparam logic signed [AccW-1:0] HalfTurnQ16 = 34'sd1179648000;
  localparam logic signed [15:0] HalfTurn = 16'sd18000;
  localparam logic signed [15:0] QuarterTurn = 16'sd9000;

  // The three packed axes, Q2.14 g.
  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } axes_t;

  // atan(2^-idx) in centidegrees with 16 fraction bits, rounded to nearest.
  function automatic logic signed [AccW-1:0] atan_q16(input int idx);
    logic signed [AccW-1:0] v;
    begin
      case (idx)
        0: v = 34'sd294912000;
        1: v = 34'sd174096719;
        2: v = 34'sd91987925;
        3: v = 34'sd46694507;
        4: v = 34'sd23437865;
        5: v = 34'sd11730358;
        6: v = 34'sd5866610;
        7: v = 34'sd2933484;
        8: v = 34'sd1466764;
        9: v = 34'sd733385;
        10: v = 34'sd366693;
        11: v = 34'sd183346;
        12: v = 34'sd91673;
        13: v = 34'sd45837;
        14: v = 34'sd22918;
        15: v = 34'sd11459;
        16: v = 34'sd5730;
        17: v = 34'sd2865;
        18: v = 34'sd1432;
        19: v = 34'sd716;
        20: v = 34'sd358;
        21: v = 34'sd179;
        22: v = 34'sd90;
        23: v = 34'sd45;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

// ----- rtl/atp_sqrt.sv -----
// ----------------------------------------------------------------------------
// atp_sqrt: pipelined integer square root
// Digit-by-digit restoring root, one result bit per register stage. The axes
// travel alongside so they leave with their root.
// ----------------------------------------------------------------------------
module atp_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [atp_pkg::RadW-1:0]     radicand,
  input  atp_pkg::axes_t               in_axes,
  output logic                         out_valid,
  output logic [atp_pkg::RootW-1:0]    root,
  output atp_pkg::axes_t               out_axes
);
  import atp_pkg::*;

  logic [RadW:0]    rem [0:RootW];
  logic [RootW-1:0] part [0:RootW];
  logic             vld [0:RootW];
  axes_t            axd [0:RootW];

  assign rem[0]  = {1'b0, radicand};
  assign part[0] = '0;
  assign vld[0]  = in_valid;
  assign axd[0]  = in_axes;

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    localparam int B = RootW - 1 - i;
    logic [RadW:0] trial;
    logic          ge;

    // Trial term (2*q + 2^B) * 2^B against the running remainder.
    assign trial = ({{(RadW+1-RootW){1'b0}}, part[i]} << (B + 1))
                 + ({{RadW{1'b0}}, 1'b1} << (2 * B));
    assign ge = (rem[i] >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= ge ? (rem[i] - trial) : rem[i];
        part[i+1] <= ge ? (part[i] | ({{(RootW-1){1'b0}}, 1'b1} << B)) : part[i];
        axd[i+1]  <= axd[i];
      end
    end
  end

  assign out_valid = vld[RootW];
  assign root      = part[RootW];
  assign out_axes  = axd[RootW];

endmodule

// ----- rtl/atp_cordic.sv -----
// ----------------------------------------------------------------------------
// atp_cordic: two-lane pipelined vectoring CORDIC
// Lane 0 gives roll, lane 1 gives pitch. A quadrant stage, one stage per
// rotation and a rounding and clamping stage, all under one enable.
// ----------------------------------------------------------------------------
module atp_cordic #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [atp_pkg::OpW-1:0]    roll_a,
  input  logic signed [atp_pkg::OpW-1:0]    roll_b,
  input  logic signed [atp_pkg::OpW-1:0]    pitch_a,
  input  logic signed [atp_pkg::OpW-1:0]    pitch_b,
  input  atp_pkg::axes_t                    in_axes,
  output logic                              out_valid,
  output logic signed [15:0]                roll,
  output logic signed [15:0]                pitch,
  output atp_pkg::axes_t                    out_axes
);
  import atp_pkg::*;

  localparam int NS = (STAGES < TableLen) ? STAGES : TableLen;

  logic signed [OpW-1:0]  ca   [0:NS][0:1];
  logic signed [OpW-1:0]  cb   [0:NS][0:1];
  logic signed [AccW-1:0] acc  [0:NS][0:1];
  logic                   spec [0:NS][0:1];
  logic signed [15:0]     fix  [0:NS][0:1];
  logic                   vld  [0:NS];
  axes_t                  axd  [0:NS];
  logic signed [OpW-1:0]  in_a [0:1];
  logic signed [OpW-1:0]  in_b [0:1];
  logic                   vld_out;
  logic signed [15:0]     res  [0:1];
  axes_t                  ax_out;

  assign in_a[0] = roll_a;
  assign in_b[0] = roll_b;
  assign in_a[1] = pitch_a;
  assign in_b[1] = pitch_b;

  // Quadrant stage: axis cases resolve here, a left half-plane flips over.
  for (genvar l = 0; l < 2; l++) begin : g_pre
    always_ff @(posedge clk) begin
      if (en) begin
        priority if (in_b[l] == '0) begin
          spec[0][l] <= 1'b1;
          fix[0][l]  <= (in_a[l] >= 0) ? 16'sd0 : HalfTurn;
        end else if (in_a[l] == '0) begin
          spec[0][l] <= 1'b1;
          fix[0][l]  <= (in_b[l] > 0) ? QuarterTurn : -QuarterTurn;
        end else begin
          spec[0][l] <= 1'b0;
          fix[0][l]  <= '0;
        end
        if (in_a[l] < 0) begin
          ca[0][l]  <= -in_a[l];
          cb[0][l]  <= -in_b[l];
          acc[0][l] <= (in_b[l] >= 0) ? HalfTurnQ16 : -HalfTurnQ16;
        end else begin
          ca[0][l]  <= in_a[l];
          cb[0][l]  <= in_b[l];
          acc[0][l] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      axd[0] <= in_axes;
    end
  end

  // Rotation stages: drive b toward zero, summing the table angles.
  for (genvar k = 0; k < NS; k++) begin : g_rot
    for (genvar l = 0; l < 2; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          if (cb[k][l] >= 0) begin
            ca[k+1][l]  <= ca[k][l] + (cb[k][l] >>> k);
            cb[k+1][l]  <= cb[k][l] - (ca[k][l] >>> k);
            acc[k+1][l] <= acc[k][l] + atan_q16(k);
          end else begin
            ca[k+1][l]  <= ca[k][l] - (cb[k][l] >>> k);
            cb[k+1][l]  <= cb[k][l] + (ca[k][l] >>> k);
            acc[k+1][l] <= acc[k][l] - atan_q16(k);
          end
          spec[k+1][l] <= spec[k][l];
          fix[k+1][l]  <= fix[k][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        axd[k+1] <= axd[k];
      end
    end
  end

  // Round to nearest centidegree and clamp to the lane's range, or pass on an axis case's fixed angle.
  for (genvar l = 0; l < 2; l++) begin : g_post
    localparam logic signed [AccW-17:0] Lim = (l == 0) ? 18'sd18000 : 18'sd9000;
    logic signed [AccW-1:0]  sum;
    logic signed [AccW-17:0] rnd;

    assign sum = acc[NS][l] + 34'sd32768;
    assign rnd = sum[AccW-1:16];

    always_ff @(posedge clk) begin
      if (en) begin
        priority if (spec[NS][l]) begin
          res[l] <= fix[NS][l];
        end else if (rnd > Lim) begin
          res[l] <= Lim[15:0];
        end else if (rnd < -Lim) begin
          res[l] <= -Lim[15:0];
        end else begin
          res[l] <= rnd[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else if (en) begin
      vld_out <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_out <= axd[NS];
    end
  end

  assign out_valid = vld_out;
  assign roll      = res[0];
  assign pitch     = res[1];
  assign out_axes  = ax_out;

endmodule

// ----- rtl/accel_tilt_angles_top.sv -----
// ----------------------------------------------------------------------------
// accel_tilt_angles_top: accelerometer roll and pitch
// Packs a six-byte frame into three axes and gives roll = atan2(y, z) and
// pitch = atan2(-x, sqrt(y*y + z*z)) in hundredths of a degree.
//
//   Channel  Dir  Handshake             Content
//   s_axis   in   tvalid/tready         one six-byte frame
//   m_axis   out  tvalid/tready         three axes, roll, pitch
//
// One item enters per cycle while the output is free; each passes through the
// packing and squaring registers, the root stages (one bit each) and the CORDIC.
// The whole pipeline advances together whenever the output register is empty
// or being taken; a stall freezes every stage in place.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module accel_tilt_angles_top #(
  parameter int ANGLE_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_high_byte, x_low_byte, y_high_byte, y_low_byte, z_high_byte, z_low_byte
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // accel_x, accel_y, accel_z, roll_centideg, pitch_centideg, one zero pad bit
  output logic [79:0] m_axis_tdata
);
  import atp_pkg::*;

  logic                 en;
  logic                 v1, v2;
  axes_t                ax1, ax2, ax_in;
  logic signed [31:0]   yy, zz;
  logic [RadW-1:0]      rad;
  logic [31:0]          sq;
  logic                 sq_valid;
  logic [RootW-1:0]     root;
  axes_t                sq_axes;
  logic signed [OpW-1:0] pitch_b;
  logic                 c_valid;
  logic signed [15:0]   roll, pitch;
  axes_t                c_axes;

  // Everything moves unless a finished item is waiting downstream.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign ax_in.x = {s_axis_tdata[7:0],   s_axis_tdata[15:8]};
  assign ax_in.y = {s_axis_tdata[23:16], s_axis_tdata[31:24]};
  assign ax_in.z = {s_axis_tdata[39:32], s_axis_tdata[47:40]};

  // Stage one: pack the axes and square y and z.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax1 <= ax_in;
      yy  <= ax_in.y * ax_in.y;
      zz  <= ax_in.z * ax_in.z;
      ax2 <= ax1;
      rad <= {sq, 16'd0};
    end
  end

  // Stage two: the sum of squares, scaled to Q8 after the root.
  assign sq = $unsigned(yy) + $unsigned(zz);

  atp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .radicand  (rad),
    .in_axes   (ax2),
    .out_valid (sq_valid),
    .root      (root),
    .out_axes  (sq_axes)
  );

  assign pitch_b = -({{(OpW-16){sq_axes.x[15]}}, sq_axes.x} <<< 8);

  atp_cordic #(
    .STAGES (ANGLE_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .roll_a    ({{(OpW-16){sq_axes.z[15]}}, sq_axes.z} <<< 8),
    .roll_b    ({{(OpW-16){sq_axes.y[15]}}, sq_axes.y} <<< 8),
    .pitch_a   ({{(OpW-RootW){1'b0}}, root}),
    .pitch_b   (pitch_b),
    .in_axes   (sq_axes),
    .out_valid (c_valid),
    .roll      (roll),
    .pitch     (pitch),
    .out_axes  (c_axes)
  );

  assign m_axis_tvalid = c_valid;
  assign m_axis_tdata  = {1'b0, pitch[14:0], roll, c_axes.z, c_axes.y, c_axes.x};

  // The input only stalls while the output register holds an item.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (roll <= 16'sd18000 && roll >= -16'sd18000))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pitch <= 16'sd9000 && pitch >= -16'sd9000))
    else $error("pitch out of range");

endmodule

// ----- tb/sv/accel_tilt_angles_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_angles_top_tb: self-checking bench for the tilt block
// Drives random and corner-case accelerometer frames through the item stream,
// predicts the axes, roll and pitch with a CORDIC model of its own, and
// compares every output item in order under several idle and stall patterns.
// ----------------------------------------------------------------------------
module accel_tilt_angles_top_tb;

  localparam int Stages = 16;
  localparam int Latency = Stages + 28;
  localparam int CycleLimit = 400000;

  // Expected contents of one output item.
  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
  } tilt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  accel_tilt_angles_top #(.ANGLE_STAGES(Stages)) dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Floor shift that is safe for negative values.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint atan_step(int i);
    longint tbl[24] = '{294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
                        5866610, 2933484, 1466764, 733385, 366693, 183346,
                        91673, 45837, 22918, 11459, 5730, 2865,
                        1432, 716, 358, 179, 90, 45};
    return tbl[i];
  endfunction

  // Vectoring CORDIC: atan2(b, a) in centidegrees, operands in Q8.
  function automatic longint cordic_angle(longint a, longint b);
    longint acc = 0;
    longint t;
    if (b == 0) return (a >= 0) ? 0 : 18000;
    if (a == 0) return (b > 0) ? 9000 : -9000;
    if (a < 0) begin
      acc = (b >= 0) ? 64'sd18000 * 65536 : -64'sd18000 * 65536;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      t = a;
      if (b >= 0) begin
        a = a + floor_shift(b, i);
        b = b - floor_shift(t, i);
        acc += atan_step(i);
      end else begin
        a = a - floor_shift(b, i);
        b = b + floor_shift(t, i);
        acc -= atan_step(i);
      end
    end
    return floor_shift(acc + 32768, 16);
  endfunction

  function automatic longint limit_to(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic tilt_t predict_tilt(logic [47:0] frame);
    tilt_t e;
    longint x, y, z, rq8;
    x = longint'($signed({frame[7:0], frame[15:8]}));
    y = longint'($signed({frame[23:16], frame[31:24]}));
    z = longint'($signed({frame[39:32], frame[47:40]}));
    rq8 = isqrt(longint'((y * y + z * z)) << 16);
    e.ax = x[15:0];
    e.ay = y[15:0];
    e.az = z[15:0];
    e.roll = 16'(limit_to(cordic_angle(z * 256, y * 256), 18000));
    e.pitch = 15'(limit_to(cordic_angle(rq8, -x * 256), 9000));
    return e;
  endfunction

  // In-order store of predicted tilt results.
  class tilt_scoreboard;
    tilt_t pending[$];

    function void note_frame(logic [47:0] frame);
      pending.push_back(predict_tilt(frame));
    endfunction

    task check_result(logic [79:0] d);
      tilt_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
        return;
      end
      e = pending.pop_front();
      if ($signed(d[15:0]) != e.ax) report_mismatch("accel_x", $signed(d[15:0]), e.ax);
      if ($signed(d[31:16]) != e.ay) report_mismatch("accel_y", $signed(d[31:16]), e.ay);
      if ($signed(d[47:32]) != e.az) report_mismatch("accel_z", $signed(d[47:32]), e.az);
      if ($signed(d[63:48]) != e.roll)
        report_mismatch("roll_centideg", $signed(d[63:48]), e.roll);
      if ($signed(d[78:64]) != e.pitch)
        report_mismatch("pitch_centideg", $signed(d[78:64]), e.pitch);
      if (d[79] !== 1'b0) report_mismatch("pad bit", d[79], 0);
    endtask
  endclass

  tilt_scoreboard board = new();

  // Frame from three signed axes, high byte first on the wire.
  function automatic logic [47:0] make_frame(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z[7:0], z[15:8], y[7:0], y[15:8], x[7:0], x[15:8]};
  endfunction

  // Offers one frame and holds it until it is taken.
  task automatic send_frame(logic [47:0] frame);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= frame;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_frame(frame);
  endtask

  // Output side: random stalls, checks on every accepted item.
  always @(posedge clk) begin
    cycles++;
    if (!rst && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (cycles > CycleLimit) begin
      $display("accel_tilt_angles_top test failed");
      $finish;
    end
  end

  function automatic logic [15:0] random_axis();
    case ($urandom_range(5))
      0: return 16'($urandom_range(65535));
      1: return 16'($signed($urandom_range(64)) - 32);
      2: return 16'($urandom_range(1)) ? 16'h8000 : 16'h7fff;
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic wait_drained();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    static logic [15:0] corner[7] = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff,
                                      16'h8000, 16'h4000, 16'hc000};
    static int pcts[4][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{38, 38}};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Corners: zeros, quadrant edges, both extremes of every axis.
    send_frame(make_frame(0, 0, 0));
    send_frame(make_frame(0, 0, 16'hc000));
    send_frame(make_frame(0, 16'h4000, 0));
    send_frame(make_frame(0, 16'hc000, 0));
    send_frame(make_frame(16'h4000, 0, 0));
    send_frame(make_frame(16'hc000, 0, 0));
    send_frame(make_frame(0, 16'h4000, 16'hc000));
    send_frame(make_frame(0, 16'hc000, 16'hc000));
    send_frame(make_frame(16'h8000, 16'h8000, 16'h8000));
    send_frame(make_frame(16'h7fff, 16'h7fff, 16'h7fff));
    send_frame(make_frame(16'h8000, 0, 16'h0001));
    send_frame(make_frame(16'h7fff, 16'h8000, 16'h7fff));
    for (int i = 0; i < 8; i++)
      send_frame(make_frame(corner[$urandom_range(6)], corner[$urandom_range(6)],
                            corner[$urandom_range(6)]));
    // Hold off until the pipeline is empty.
    s_axis_tvalid <= 1'b0;
    wait_drained();
    // Random frames across the idle and stall phases.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = pcts[p][0];
      recv_stall_pct = pcts[p][1];
      for (int i = 0; i < 360; i++)
        send_frame(make_frame(random_axis(), random_axis(), random_axis()));
    end
    s_axis_tvalid <= 1'b0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("accel_tilt_angles_top test passed");
    end else begin
      $display("accel_tilt_angles_top test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/atp_pkg.sv
rtl/atp_sqrt.sv
rtl/atp_cordic.sv
rtl/accel_tilt_angles_top.sv
tb/sv/accel_tilt_angles_top_tb.sv
